FILE: rtl/set_assoc_cache_lru_tags_assert.svh
// Assertion macros shared by the cache tag store RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SET_ASSOC_CACHE_LRU_TAGS_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache tag store assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache tag store assertion failed");

`endif

FILE: rtl/sacl_pkg.sv
// Shared types for the set-associative cache tag store.
// Used by sacl_setidx, sacl_tags and set_assoc_cache_lru_tags.
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

	typedef enum logic [1:0] {
		MK_HIT      = 2'd0,
		MK_FILL     = 2'd1,
		MK_CONFLICT = 2'd2
	} miss_kind_t;

	typedef struct packed {
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic fire;
	} sacl_ctl_t;

	typedef struct packed {
		logic       hit;
		miss_kind_t kind;
	} sacl_look_t;

endpackage

`default_nettype wire

FILE: rtl/set_assoc_cache_lru_tags.sv
// Top level of the set-associative cache tag store with LRU replacement.
// Depends on sacl_pkg, sacl_setidx, sacl_tags and the assert header.
//
// Channel   Direction  Handshake             Payload
// request   in         req_valid/req_stall   block_number
// result    out        res_valid/res_stall   set_index, hit, way_used, miss_kind,
//                                            evicted_block, hit/miss/conflict_count
//
// One request is accepted per cycle while req_stall is low; each result passes through
// three set index stages, the registered tag RAM read and the result register.
// After reset a clearing pass writes every set row; req_stall stays high during it.
// A stalled result holds its register; empty stages behind it keep filling.
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_lru_tags_assert.svh"

module set_assoc_cache_lru_tags #(
	parameter int SETS       = 4,
	parameter int WAYS       = 2,
	parameter int BLOCK_BITS = 16,
	parameter int COUNT_BITS = 32,
	localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1,
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    req_valid,
	output logic                         req_stall,
	input  wire logic [BLOCK_BITS-1:0]   block_number,
	output logic                         res_valid,
	input  wire logic                    res_stall,
	output logic      [SET_BITS-1:0]     set_index,
	output logic                         hit,
	output logic      [WAY_BITS-1:0]     way_used,
	output logic      [1:0]              miss_kind,
	output logic      [BLOCK_BITS-1:0]   evicted_block,
	output logic      [COUNT_BITS-1:0]   hit_count,
	output logic      [COUNT_BITS-1:0]   miss_count,
	output logic      [COUNT_BITS-1:0]   conflict_count
);

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic                  valid_s4;
	logic                  res_valid_q;
	logic                  out_free;
	logic                  free_s1;
	logic                  free_s2;
	logic                  free_s3;
	logic                  free_s4;
	logic                  accept;
	logic                  clearing;
	logic [BLOCK_BITS-1:0] block_s1;
	logic [BLOCK_BITS-1:0] block_s4;
	logic [SET_BITS-1:0]   set_s4;
	logic [SET_BITS-1:0]   set_rd;
	logic [WAY_BITS-1:0]   way;
	logic [BLOCK_BITS-1:0] evicted;

	sacl_pkg::sacl_ctl_t   ctl;
	sacl_pkg::sacl_look_t  look;

	logic [SET_BITS-1:0]   set_index_q;
	logic                  hit_q;
	logic [WAY_BITS-1:0]   way_used_q;
	sacl_pkg::miss_kind_t  miss_kind_q;
	logic [BLOCK_BITS-1:0] evicted_q;

	assign out_free  = !res_valid_q || !res_stall;
	assign free_s4   = !valid_s4 || out_free;
	assign free_s3   = !valid_s3 || free_s4;
	assign free_s2   = !valid_s2 || free_s3;
	assign free_s1   = !valid_s1 || free_s2;
	assign req_stall = !free_s1 || clearing;
	assign accept    = req_valid && !req_stall;

	assign ctl.en_s2 = valid_s1 && free_s2;
	assign ctl.en_s3 = valid_s2 && free_s3;
	assign ctl.en_s4 = valid_s3 && free_s4;
	assign ctl.fire  = valid_s4 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= accept;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (free_s3) begin
				valid_s3 <= valid_s2;
			end
			if (free_s4) begin
				valid_s4 <= valid_s3;
			end
			if (out_free) begin
				res_valid_q <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			block_s1 <= block_number;
		end
	end

	sacl_setidx #(
		.SETS       (SETS),
		.BLOCK_BITS (BLOCK_BITS)
	) u_setidx (
		.clk      (clk),
		.ctl      (ctl),
		.block_s1 (block_s1),
		.block_s4 (block_s4),
		.set_s4   (set_s4),
		.set_rd   (set_rd)
	);

	sacl_tags #(
		.SETS       (SETS),
		.WAYS       (WAYS),
		.BLOCK_BITS (BLOCK_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_tags (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.set_rd   (set_rd),
		.set_s4   (set_s4),
		.block_s4 (block_s4),
		.clearing (clearing),
		.look     (look),
		.way      (way),
		.evicted  (evicted),
		.hit_cnt  (hit_count),
		.miss_cnt (miss_count),
		.conf_cnt (conflict_count)
	);

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			set_index_q <= set_s4;
			hit_q       <= look.hit;
			way_used_q  <= way;
			miss_kind_q <= look.kind;
			evicted_q   <= evicted;
		end
	end

	assign res_valid     = res_valid_q;
	assign set_index     = set_index_q;
	assign hit           = hit_q;
	assign way_used      = way_used_q;
	assign miss_kind     = miss_kind_q;
	assign evicted_block = evicted_q;

	`SACL_ASSERT_NXT(a_fire_loads_result, clk, arst_n, ctl.fire, res_valid_q)
	`SACL_ASSERT_NOW(a_stall_while_clearing, clk, arst_n, clearing, req_stall && !valid_s1 && !valid_s4)

endmodule

`default_nettype wire

FILE: rtl/sacl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic [ADDR_BITS-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]       wr_data,
	input  wire logic                   rd_en,
	input  wire logic [ADDR_BITS-1:0]   rd_addr,
	output logic      [WIDTH-1:0]       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sacl_setidx.sv
// Set index pipeline: block number modulo SETS over three stages.
// Depends on sacl_pkg for the stage control struct.
`timescale 1ns / 1ps
`default_nettype none

module sacl_setidx #(
	parameter int SETS       = 4,
	parameter int BLOCK_BITS = 16,
	localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1
) (
	input  wire logic                    clk,
	input  wire sacl_pkg::sacl_ctl_t     ctl,
	input  wire logic [BLOCK_BITS-1:0]   block_s1,
	output logic      [BLOCK_BITS-1:0]   block_s4,
	output logic      [SET_BITS-1:0]     set_s4,
	output logic      [SET_BITS-1:0]     set_rd
);

	localparam int SUM_MAX  = BLOCK_BITS * (SETS - 1);
	localparam int SUM_BITS = (SUM_MAX > 0) ? $clog2(SUM_MAX + 1) : 1;
	localparam int K        = SUM_BITS + 11;
	localparam int MB       = K + 1;
	localparam int PB       = SUM_BITS + MB;
	localparam longint unsigned MREC = (64'd1 << K) / SETS;

	function automatic int wt(input int bit_i);
		int w;
		w = (SETS > 1) ? 1 : 0;
		for (int k = 0; k < bit_i; k++) begin
			w = 2 * w;
			if (w >= SETS) begin
				w = w - SETS;
			end
		end
		return w;
	endfunction

	logic [SUM_BITS-1:0]   term [BLOCK_BITS];
	logic [SUM_BITS-1:0]   sum_nxt;
	logic [BLOCK_BITS-1:0] block_s2;
	logic [SUM_BITS-1:0]   sum_s2;
	logic [PB-1:0]         prod;
	logic [BLOCK_BITS-1:0] block_s3;
	logic [SUM_BITS-1:0]   sum_s3;
	logic [SUM_BITS-1:0]   q_s3;
	logic [SUM_BITS-1:0]   qs;
	logic [SUM_BITS-1:0]   rem;
	logic [SUM_BITS-1:0]   rem_fix;

	for (genvar i = 0; i < BLOCK_BITS; i++) begin : g_term
		localparam int W = wt(i);
		assign term[i] = block_s1[i] ? SUM_BITS'(W) : '0;
	end

	always_comb begin
		sum_nxt = '0;
		for (int i = 0; i < BLOCK_BITS; i++) begin
			sum_nxt = sum_nxt + term[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			block_s2 <= block_s1;
			sum_s2   <= sum_nxt;
		end
	end

	assign prod = PB'(sum_s2) * PB'(MREC);

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			block_s3 <= block_s2;
			sum_s3   <= sum_s2;
			q_s3     <= prod[K +: SUM_BITS];
		end
	end

	assign qs      = q_s3 * SUM_BITS'(SETS);
	assign rem     = sum_s3 - qs;
	assign rem_fix = (rem >= SUM_BITS'(SETS)) ? (rem - SUM_BITS'(SETS)) : rem;
	assign set_rd  = SET_BITS'(rem_fix);

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			block_s4 <= block_s3;
			set_s4   <= set_rd;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sacl_tags.sv
// Tag store: set row RAM with clearing pass, way lookup, LRU rank update
// and saturating totals. Depends on sacl_pkg, sacl_ram and the assert header.
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_lru_tags_assert.svh"

module sacl_tags #(
	parameter int SETS       = 4,
	parameter int WAYS       = 2,
	parameter int BLOCK_BITS = 16,
	parameter int COUNT_BITS = 32,
	localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1,
	localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire sacl_pkg::sacl_ctl_t     ctl,
	input  wire logic [SET_BITS-1:0]     set_rd,
	input  wire logic [SET_BITS-1:0]     set_s4,
	input  wire logic [BLOCK_BITS-1:0]   block_s4,
	output logic                         clearing,
	output sacl_pkg::sacl_look_t         look,
	output logic      [WAY_BITS-1:0]     way,
	output logic      [BLOCK_BITS-1:0]   evicted,
	output logic      [COUNT_BITS-1:0]   hit_cnt,
	output logic      [COUNT_BITS-1:0]   miss_cnt,
	output logic      [COUNT_BITS-1:0]   conf_cnt
);

	localparam int RANK_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int LINE_BITS = 1 + RANK_BITS + BLOCK_BITS;
	localparam int ROW_BITS  = WAYS * LINE_BITS;

	logic                  clr_q;
	logic [SET_BITS-1:0]   clr_idx_q;
	logic                  wr_en;
	logic [SET_BITS-1:0]   wr_addr;
	logic [ROW_BITS-1:0]   wr_data;
	logic [ROW_BITS-1:0]   rd_data;
	logic [ROW_BITS-1:0]   row;
	logic [ROW_BITS-1:0]   row_nxt;
	logic                  byp_q;
	logic [ROW_BITS-1:0]   byp_row_q;

	logic [WAYS-1:0]       vld;
	logic [RANK_BITS-1:0]  rank [WAYS];
	logic [BLOCK_BITS-1:0] tag  [WAYS];
	logic [WAYS-1:0]       match;

	logic                  hit_any;
	logic                  any_empty;
	logic [WAY_BITS-1:0]   hit_way;
	logic [WAY_BITS-1:0]   empty_way;
	logic [WAY_BITS-1:0]   lru_way;
	logic [WAY_BITS-1:0]   way_sel;
	logic [RANK_BITS:0]    old_rank;

	logic [COUNT_BITS-1:0] hits_q;
	logic [COUNT_BITS-1:0] misses_q;
	logic [COUNT_BITS-1:0] confs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == SET_BITS'(SETS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_idx_q <= clr_idx_q + 1'b1;
		end
	end

	assign clearing = clr_q;
	assign wr_en    = clr_q || ctl.fire;
	assign wr_addr  = clr_q ? clr_idx_q : set_s4;
	assign wr_data  = clr_q ? '0 : row_nxt;

	sacl_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (SETS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.en_s4),
		.rd_addr (set_rd),
		.rd_data (rd_data)
	);

	// A row written at the same edge it is read comes from the write data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (ctl.en_s4) begin
			byp_q <= ctl.fire && (set_s4 == set_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			byp_row_q <= wr_data;
		end
	end

	assign row = byp_q ? byp_row_q : rd_data;

	for (genvar w = 0; w < WAYS; w++) begin : g_line
		assign vld[w]   = row[w * LINE_BITS + BLOCK_BITS + RANK_BITS];
		assign rank[w]  = row[w * LINE_BITS + BLOCK_BITS +: RANK_BITS];
		assign tag[w]   = row[w * LINE_BITS +: BLOCK_BITS];
		assign match[w] = vld[w] && (tag[w] == block_s4);
	end

	always_comb begin
		hit_way   = '0;
		empty_way = '0;
		lru_way   = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_BITS'(w);
			end
			if (rank[w] == RANK_BITS'(WAYS - 1)) begin
				lru_way = WAY_BITS'(w);
			end
		end
		for (int w = 0; w < WAYS; w++) begin
			if (!vld[w]) begin
				empty_way = WAY_BITS'(w);
			end
		end
	end

	assign hit_any   = |match;
	assign any_empty = ~&vld;

	always_comb begin
		look.hit = hit_any;
		if (hit_any) begin
			way_sel   = hit_way;
			look.kind = sacl_pkg::MK_HIT;
		end else if (any_empty) begin
			way_sel   = empty_way;
			look.kind = sacl_pkg::MK_FILL;
		end else begin
			way_sel   = lru_way;
			look.kind = sacl_pkg::MK_CONFLICT;
		end
	end

	assign way     = way_sel;
	assign evicted = (look.kind == sacl_pkg::MK_CONFLICT) ? tag[lru_way] : '0;

	assign old_rank = vld[way_sel] ? {1'b0, rank[way_sel]} : (RANK_BITS + 1)'(WAYS);

	always_comb begin
		row_nxt = row;
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_BITS'(w) == way_sel) begin
				row_nxt[w * LINE_BITS +: LINE_BITS] = {1'b1, {RANK_BITS{1'b0}}, block_s4};
			end else if (vld[w] && ({1'b0, rank[w]} < old_rank)) begin
				row_nxt[w * LINE_BITS + BLOCK_BITS +: RANK_BITS] = rank[w] + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			confs_q  <= '0;
		end else if (ctl.fire) begin
			if (hit_any) begin
				if (!(&hits_q)) begin
					hits_q <= hits_q + 1'b1;
				end
			end else begin
				if (!(&misses_q)) begin
					misses_q <= misses_q + 1'b1;
				end
				if (!any_empty && !(&confs_q)) begin
					confs_q <= confs_q + 1'b1;
				end
			end
		end
	end

	assign hit_cnt  = hits_q;
	assign miss_cnt = misses_q;
	assign conf_cnt = confs_q;

	`SACL_ASSERT_NOW(a_no_fire_while_clearing, clk, arst_n, clr_q, !ctl.fire && !ctl.en_s4)
	`SACL_ASSERT_NXT(a_hit_counts, clk, arst_n, ctl.fire && hit_any, (hits_q == $past(hits_q) + 1'b1) || (&$past(hits_q)))
	`SACL_ASSERT_NXT(a_miss_counts, clk, arst_n, ctl.fire && !hit_any, (misses_q == $past(misses_q) + 1'b1) || (&$past(misses_q)))

endmodule

`default_nettype wire
